[rtl/cfss_pkg.sv]
`default_nettype none

package cfss_pkg;

    // Frame size in bytes (legal range 2 to 8): id, value bytes, padding, checksum.
    localparam int FRAME_BYTES = 4;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;

    // Bit counter width; the count wraps at 64, as the frame can hold up to 64 bits.
    localparam int BIT_CNT_W = 6;

    // Repetition counter and register widths.
    localparam int REP_W = 4;
    localparam logic [REP_W-1:0] REPEAT_RESET = 4'd4;

    // Request codes of an input word.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

endpackage

`default_nettype wire

[rtl/cfss_frame_builder.sv]
`default_nettype none

module cfss_frame_builder
    import cfss_pkg::*;
(
    input  wire logic [7:0]            setting_id,
    input  wire logic [15:0]           setting_value,
    output logic      [FRAME_BITS-1:0] frame
);

    logic [7:0]            frame_byte;
    logic [7:0]            sum;
    logic [FRAME_BITS-1:0] acc;

    // Pack id, value high, value low and zero padding, keeping a wrapping
    // byte sum; the complement of the sum closes the frame.
    always_comb
    begin
        sum = 8'h00;
        acc = '0;
        frame_byte = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
        begin
            if (i == 0)
                frame_byte = setting_id;
            else if (i == 1)
                frame_byte = setting_value[15:8];
            else if (i == 2)
                frame_byte = setting_value[7:0];
            else
                frame_byte = 8'h00;
            sum = sum + frame_byte;
            acc = {acc[FRAME_BITS-9:0], frame_byte};
        end
        frame = {acc[FRAME_BITS-9:0], ~sum};
    end

endmodule

`default_nettype wire

[rtl/checksummed_frame_spi_sender_core.sv]
`default_nettype none

// Channel   Handshake                  Payload
// ------    -----------------------    ----------------------------------------------
// input     in_valid / in_stall        req_type, setting_id, setting_value
// output    out_valid / out_stall      chip_select_n, serial_clock, serial_data,
//                                      busy_res, load_accepted, sequence_done
// config    cfg_write                  cfg_data (repeat_count)
//
// Every input word is handled at once: the serializer state and the result
// register are updated together at the edge that accepts the word.
// A new word is accepted every cycle while the result register is empty or drains.
// in_stall is high only while a result waits and out_stall holds it.
// Reset leaves the link idle: chip select high, clock and data low, repeat count 4.

module checksummed_frame_spi_sender_core
    import cfss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write,
    input  wire logic [3:0]  cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [7:0]  setting_id,
    input  wire logic [15:0] setting_value,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             chip_select_n,
    output logic             serial_clock,
    output logic             serial_data,
    output logic             busy_res,
    output logic             load_accepted,
    output logic             sequence_done
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ARMED,
        PH_SELECTED,
        PH_DATA,
        PH_HIGH,
        PH_TAIL,
        PH_GAP
    } phase_t;

    phase_t                phase_reg, phase_next, phase_cur;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [BIT_CNT_W-1:0]  bitpos_reg, bitpos_next;
    logic [REP_W-1:0]      reps_reg, reps_next;
    logic [REP_W-1:0]      repeat_reg;
    logic                  cs_reg, cs_next, cs_cur;
    logic                  clk_reg, clk_next;
    logic                  data_reg, data_next;
    logic                  accepted_next, done_next;
    logic [FRAME_BITS-1:0] built_frame;
    logic                  in_accept;

    logic                  out_valid_reg;
    logic                  out_cs_reg, out_clk_reg, out_data_reg;
    logic                  out_busy_reg, out_acc_reg, out_done_reg;

    cfss_frame_builder u_builder (
        .setting_id    (setting_id),
        .setting_value (setting_value),
        .frame         (built_frame)
    );

    // The input side stalls only while a result waits and cannot be taken.
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repeat_reg <= REPEAT_RESET;
        else if (cfg_write)
            repeat_reg <= cfg_data;
    end

    // Serializer step for one word.
    always_comb
    begin
        // A phase code outside the list behaves as idle with chip select high.
        phase_cur = phase_reg;
        cs_cur    = cs_reg;
        case (phase_reg)
            PH_IDLE, PH_ARMED, PH_SELECTED, PH_DATA, PH_HIGH, PH_TAIL, PH_GAP:
            begin
                phase_cur = phase_reg;
            end
            default:
            begin
                phase_cur = PH_IDLE;
                cs_cur    = 1'b1;
            end
        endcase

        phase_next    = phase_cur;
        frame_next    = frame_reg;
        shift_next    = shift_reg;
        bitpos_next   = bitpos_reg;
        reps_next     = reps_reg;
        cs_next       = cs_cur;
        clk_next      = clk_reg;
        data_next     = data_reg;
        accepted_next = 1'b0;
        done_next     = 1'b0;

        if (phase_cur == PH_IDLE && phase_reg != PH_IDLE)
        begin
            clk_next  = 1'b0;
            data_next = 1'b0;
        end

        if (req_type == REQ_LOAD)
        begin
            if (phase_cur == PH_IDLE)
            begin
                frame_next    = built_frame;
                reps_next     = (repeat_reg == '0) ? REP_W'(1) : repeat_reg;
                bitpos_next   = '0;
                phase_next    = PH_ARMED;
                accepted_next = 1'b1;
            end
        end
        else
        begin
            case (phase_cur)
                PH_ARMED:
                begin
                    shift_next  = frame_reg;
                    bitpos_next = '0;
                    cs_next     = 1'b0;
                    clk_next    = 1'b0;
                    data_next   = 1'b0;
                    phase_next  = PH_SELECTED;
                end
                PH_SELECTED:
                begin
                    cs_next    = 1'b0;
                    clk_next   = 1'b0;
                    data_next  = shift_reg[FRAME_BITS-1];
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    clk_next   = 1'b1;
                    phase_next = PH_HIGH;
                end
                PH_HIGH:
                begin
                    bitpos_next = bitpos_reg + 1'b1;
                    shift_next  = {shift_reg[FRAME_BITS-2:0], 1'b0};
                    // The count wraps to zero after 64 bits, which also ends the frame.
                    if (bitpos_next != '0 &&
                        {1'b0, bitpos_next} < (BIT_CNT_W + 1)'(FRAME_BITS))
                    begin
                        cs_next    = 1'b0;
                        clk_next   = 1'b0;
                        data_next  = shift_reg[FRAME_BITS-2];
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        clk_next   = 1'b0;
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    cs_next    = 1'b1;
                    clk_next   = 1'b0;
                    data_next  = 1'b0;
                    phase_next = PH_GAP;
                end
                PH_GAP:
                begin
                    reps_next = reps_reg - 1'b1;
                    if (reps_next != '0)
                    begin
                        shift_next  = frame_reg;
                        bitpos_next = '0;
                        cs_next     = 1'b0;
                        clk_next    = 1'b0;
                        data_next   = 1'b0;
                        phase_next  = PH_SELECTED;
                    end
                    else
                    begin
                        cs_next    = 1'b1;
                        clk_next   = 1'b0;
                        data_next  = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase
        end
    end

    // Serializer state and result register, committed when a word is accepted.
    // The result flag drops once a waiting word has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            frame_reg     <= '0;
            shift_reg     <= '0;
            bitpos_reg    <= '0;
            reps_reg      <= '0;
            cs_reg        <= 1'b1;
            clk_reg       <= 1'b0;
            data_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_cs_reg    <= 1'b1;
            out_clk_reg   <= 1'b0;
            out_data_reg  <= 1'b0;
            out_busy_reg  <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg     <= phase_next;
            frame_reg     <= frame_next;
            shift_reg     <= shift_next;
            bitpos_reg    <= bitpos_next;
            reps_reg      <= reps_next;
            cs_reg        <= cs_next;
            clk_reg       <= clk_next;
            data_reg      <= data_next;
            out_valid_reg <= 1'b1;
            out_cs_reg    <= cs_next;
            out_clk_reg   <= clk_next;
            out_data_reg  <= data_next;
            out_busy_reg  <= (phase_next != PH_IDLE);
            out_acc_reg   <= accepted_next;
            out_done_reg  <= done_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign chip_select_n = out_cs_reg;
    assign serial_clock  = out_clk_reg;
    assign serial_data   = out_data_reg;
    assign busy_res      = out_busy_reg;
    assign load_accepted = out_acc_reg;
    assign sequence_done = out_done_reg;

endmodule

`default_nettype wire

[rtl/cfss_checker.sv]
`default_nettype none

module cfss_checker
    import cfss_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        chip_select_n,
    input wire logic        serial_clock,
    input wire logic        serial_data,
    input wire logic        busy_res,
    input wire logic        load_accepted,
    input wire logic        sequence_done
);

    // A stalled result word keeps its line levels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chip_select_n)
            && $stable(serial_clock) && $stable(serial_data))
        else $error("stalled result word changed");

    // A load that started a transmission leaves the sender busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && load_accepted |-> busy_res)
        else $error("accepted load without busy");

    // The end of a sequence leaves the link idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sequence_done |-> !busy_res && chip_select_n
            && !serial_clock && !serial_data && !load_accepted)
        else $error("sequence end with link not idle");

    // The clock only pulses while the slave is selected.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && serial_clock |-> !chip_select_n && busy_res)
        else $error("clock pulse without chip select");

endmodule

bind checksummed_frame_spi_sender_core cfss_checker u_cfss_checker (.*);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import cfss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;

    // Serializer stages of the link, in the order a frame passes through them.
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ARMED,
        ST_SELECTED,
        ST_DATA,
        ST_HIGH,
        ST_TAIL,
        ST_GAP
    } link_stage_t;

    // One input word: a load of a setting or a single timing tick.
    typedef struct packed
    {
        logic        kind;
        logic [7:0]  id;
        logic [15:0] value;
    } link_req_t;

    // Line levels and flags reported after each word.
    typedef struct packed
    {
        logic cs_n;
        logic sclk;
        logic mosi;
        logic busy;
        logic started;
        logic finished;
    } link_levels_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       cfg_write = 1'b0;
    logic [3:0] cfg_data = '0;

    logic      in_valid = 1'b0;
    logic      in_stall;
    link_req_t offered = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic chip_select_n;
    logic serial_clock;
    logic serial_data;
    logic busy_res;
    logic load_accepted;
    logic sequence_done;

    // Words waiting to be offered and line levels waiting to be seen.
    link_req_t    pending_reqs[$];
    link_levels_t awaited_lines[$];
    link_levels_t want;

    int sender_gap_pct = 10;
    int receiver_stall_pct = 73;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;

    // Shadow of the serializer and of the repeat register.
    logic [FRAME_BITS-1:0] frame_bits = '0;
    logic [FRAME_BITS-1:0] shifter = '0;
    logic [BIT_CNT_W-1:0]  bits_sent = '0;
    logic [REP_W-1:0]      reps_left = '0;
    logic [REP_W-1:0]      repeat_setting = REPEAT_RESET;
    link_stage_t           link_stage = ST_IDLE;
    logic                  cs_level = 1'b1;
    logic                  clk_level = 1'b0;
    logic                  data_level = 1'b0;

    checksummed_frame_spi_sender_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (offered.kind),
        .setting_id    (offered.id),
        .setting_value (offered.value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .chip_select_n (chip_select_n),
        .serial_clock  (serial_clock),
        .serial_data   (serial_data),
        .busy_res      (busy_res),
        .load_accepted (load_accepted),
        .sequence_done (sequence_done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Frame layout: id, value high byte, value low byte, zero padding, then the
    // complement of the wrapping byte sum of everything before it.
    function automatic logic [FRAME_BITS-1:0] frame_of(input logic [7:0] id,
                                                        input logic [15:0] value);
        logic [FRAME_BITS-1:0] f;
        logic [7:0]            sum;
        logic [7:0]            b;
        int                    i;
        f = '0;
        sum = '0;
        for (i = 0; i < FRAME_BYTES - 1; i++)
        begin
            if (i == 0)
                b = id;
            else if (i == 1)
                b = value[15:8];
            else if (i == 2)
                b = value[7:0];
            else
                b = 8'h00;
            sum = sum + b;
            f = {f[FRAME_BITS-9:0], b};
        end
        f = {f[FRAME_BITS-9:0], ~sum};
        return f;
    endfunction

    // Advances the shadow serializer by one word and returns the expected levels.
    function automatic link_levels_t spi_link_step(input link_req_t req);
        logic started;
        logic finished;
        started = 1'b0;
        finished = 1'b0;
        if (req.kind == REQ_LOAD)
        begin
            // A load is only taken while the link is idle.
            if (link_stage == ST_IDLE)
            begin
                frame_bits = frame_of(req.id, req.value);
                reps_left = (repeat_setting == '0) ? REP_W'(1) : repeat_setting;
                bits_sent = '0;
                link_stage = ST_ARMED;
                started = 1'b1;
            end
        end
        else
        begin
            case (link_stage)
                ST_ARMED:
                begin
                    shifter = frame_bits;
                    bits_sent = '0;
                    {cs_level, clk_level, data_level} = 3'b000;
                    link_stage = ST_SELECTED;
                end
                ST_SELECTED:
                begin
                    {cs_level, clk_level} = 2'b00;
                    data_level = shifter[FRAME_BITS-1];
                    link_stage = ST_DATA;
                end
                ST_DATA:
                begin
                    clk_level = 1'b1;
                    link_stage = ST_HIGH;
                end
                ST_HIGH:
                begin
                    bits_sent = bits_sent + 1'b1;
                    shifter = shifter << 1;
                    if (bits_sent != '0 && int'(bits_sent) < FRAME_BITS)
                    begin
                        {cs_level, clk_level} = 2'b00;
                        data_level = shifter[FRAME_BITS-1];
                        link_stage = ST_DATA;
                    end
                    else
                    begin
                        clk_level = 1'b0;
                        link_stage = ST_TAIL;
                    end
                end
                ST_TAIL:
                begin
                    {cs_level, clk_level, data_level} = 3'b100;
                    link_stage = ST_GAP;
                end
                ST_GAP:
                begin
                    reps_left = reps_left - 1'b1;
                    if (reps_left != '0)
                    begin
                        shifter = frame_bits;
                        bits_sent = '0;
                        {cs_level, clk_level, data_level} = 3'b000;
                        link_stage = ST_SELECTED;
                    end
                    else
                    begin
                        {cs_level, clk_level, data_level} = 3'b100;
                        link_stage = ST_IDLE;
                        finished = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        return '{cs_level, clk_level, data_level, link_stage != ST_IDLE, started, finished};
    endfunction

    task automatic compare_line(input string name, input logic expected_level,
                                input logic actual_level);
        if (expected_level !== actual_level)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b",
                     $time, name, expected_level, actual_level);
            mismatches++;
        end
    endtask

    // Sender: predicts each accepted word, then offers the next pending one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                awaited_lines.push_back(spi_link_step(offered));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_gap_pct)
                begin
                    offered <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result word against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_lines.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected none, actual %b",
                             $time, {chip_select_n, serial_clock, serial_data,
                                     busy_res, load_accepted, sequence_done});
                    mismatches++;
                end
                else
                begin
                    want = awaited_lines.pop_front();
                    compare_line("chip_select_n", want.cs_n, chip_select_n);
                    compare_line("serial_clock", want.sclk, serial_clock);
                    compare_line("serial_data", want.mosi, serial_data);
                    compare_line("busy_res", want.busy, busy_res);
                    compare_line("load_accepted", want.started, load_accepted);
                    compare_line("sequence_done", want.finished, sequence_done);
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Long receiver hold-off, started on request from the stimulus.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_requests != hold_seen)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_req(input logic kind, input logic [7:0] id,
                            input logic [15:0] value);
        pending_reqs.push_back('{kind, id, value});
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || awaited_lines.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Ticks the link until the current sequence has run to its end.
    task automatic finish_sequence();
        wait_drained();
        while (link_stage != ST_IDLE)
        begin
            repeat (16) push_req(REQ_TICK, 8'($urandom), 16'($urandom));
            wait_drained();
        end
    endtask

    task automatic write_repeat(input logic [3:0] count);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_write <= 1'b0;
        repeat_setting = count;
        @(negedge clk);
    endtask

    // Mostly a load followed by a run of ticks, with stray loads landing while
    // busy; the rest is single words of random kind.
    task automatic queue_random_traffic(input int count);
        int queued;
        int run;
        int k;
        queued = 0;
        while (queued < count)
        begin
            if ($urandom_range(99) < 8)
            begin
                push_req(1'($urandom_range(1)), 8'($urandom), 16'($urandom));
                queued++;
            end
            else
            begin
                push_req(REQ_LOAD, 8'($urandom), 16'($urandom));
                run = $urandom_range(70, 1);
                for (k = 0; k < run; k++)
                begin
                    if ($urandom_range(99) < 4)
                        push_req(REQ_LOAD, 8'($urandom), 16'($urandom));
                    else
                        push_req(REQ_TICK, 8'($urandom), 16'($urandom));
                end
                queued += run + 1;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset repeat count: a tick while idle, loads of
        // the field extremes, and loads arriving while a frame is going out.
        push_req(REQ_TICK, 8'h00, 16'h0000);
        push_req(REQ_LOAD, 8'h00, 16'h0000);
        repeat (3) push_req(REQ_TICK, 8'h00, 16'h0000);
        push_req(REQ_LOAD, 8'hFF, 16'hFFFF);
        repeat (5) push_req(REQ_TICK, 8'hFF, 16'hFFFF);
        push_req(REQ_LOAD, 8'hA5, 16'h5A3C);
        repeat (4) push_req(REQ_TICK, 8'h00, 16'h0000);
        finish_sequence();
        push_req(REQ_LOAD, 8'hFF, 16'hFFFF);
        push_req(REQ_TICK, 8'h00, 16'h0000);
        finish_sequence();
        queue_random_traffic(200);
        finish_sequence();

        // Single repetition.
        write_repeat(4'd1);
        queue_random_traffic(250);
        finish_sequence();

        // Sender now idles more than the receiver stalls.
        sender_gap_pct = 73;
        receiver_stall_pct = 10;
        write_repeat(4'd15);
        queue_random_traffic(250);
        finish_sequence();

        // A zero count behaves as one repetition.
        write_repeat(4'd0);
        queue_random_traffic(200);
        finish_sequence();

        // No idling on either side, with one long receiver hold-off that backs
        // the block up while the sender keeps offering words.
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        write_repeat(4'($urandom_range(14, 2)));
        queue_random_traffic(100);
        hold_requests++;
        queue_random_traffic(150);
        finish_sequence();

        if (mismatches == 0 && awaited_lines.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
